[sv/se2u_pkg.sv]
// shared types and constants for the string escape decoder
`default_nettype none

package se2u_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BIG   = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_UESC,
        PH_HEX
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BYTE,
        KIND_UTF8
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [20:0] cp;
        logic [1:0]  status;
        logic        term;
        logic        term_err;
    } cmd_t;

endpackage

`default_nettype wire

[sv/se2u_front.sv]
// front end: escape scanner that turns input beats into output commands
`default_nettype none

module se2u_front import se2u_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_has_byte,
    input  wire logic       s_last,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd
);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_Q         = 8'h71;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [24:0] CP_MAX      = 25'h10FFFF;
    localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;

    phase_t      phase_reg, phase_next;
    logic [20:0] cp_reg, cp_next;
    logic        ovf_reg, ovf_next;
    logic        seen_reg, seen_next;
    logic        drain_reg, drain_next;

    logic        hex_ok;
    logic [3:0]  hex_v;
    logic [24:0] full_cp;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        hex_ok = 1'b1;
        hex_v  = 4'd0;
        if (s_in_byte >= 8'h30 && s_in_byte <= 8'h39) begin
            hex_v = 4'(s_in_byte - 8'h30);
        end else if (s_in_byte >= 8'h61 && s_in_byte <= 8'h66) begin
            hex_v = 4'(s_in_byte - 8'h57);
        end else if (s_in_byte >= 8'h41 && s_in_byte <= 8'h46) begin
            hex_v = 4'(s_in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign full_cp = {cp_reg, hex_v};

    always_comb begin
        phase_next = phase_reg;
        cp_next    = cp_reg;
        ovf_next   = ovf_reg;
        seen_next  = seen_reg;
        drain_next = drain_reg;
        q_cmd      = '{kind: KIND_NONE, cp: 21'd0, status: ST_OK, term: 1'b0, term_err: 1'b0};

        if (s_has_byte && !drain_reg) begin
            unique case (phase_reg)
                PH_ESC: begin
                    phase_next = PH_TEXT;
                    q_cmd.kind = KIND_BYTE;
                    unique case (s_in_byte)
                        CH_Q:         q_cmd.cp = {13'd0, CH_QUOTE};
                        CH_N:         q_cmd.cp = {13'd0, CH_LF};
                        CH_R:         q_cmd.cp = {13'd0, CH_CR};
                        CH_T:         q_cmd.cp = {13'd0, CH_TAB};
                        CH_BACKSLASH: q_cmd.cp = {13'd0, CH_BACKSLASH};
                        CH_U: begin
                            q_cmd.kind = KIND_NONE;
                            phase_next = PH_UESC;
                        end
                        default: begin
                            q_cmd.kind = KIND_NONE;
                            drain_next = 1'b1;
                        end
                    endcase
                end
                PH_UESC: begin
                    if (s_in_byte == CH_LBRACE) begin
                        phase_next = PH_HEX;
                        cp_next    = 21'd0;
                        ovf_next   = 1'b0;
                        seen_next  = 1'b0;
                    end else begin
                        phase_next = PH_TEXT;
                        drain_next = 1'b1;
                    end
                end
                PH_HEX: begin
                    if (s_in_byte == CH_RBRACE) begin
                        phase_next = PH_TEXT;
                        q_cmd.kind = KIND_UTF8;
                        if (ovf_reg) begin
                            q_cmd.cp     = CP_REPLACE;
                            q_cmd.status = ST_BIG;
                        end else begin
                            q_cmd.cp     = cp_reg;
                            q_cmd.status = seen_reg ? ST_OK : ST_EMPTY;
                        end
                    end else if (hex_ok) begin
                        if (full_cp > CP_MAX) ovf_next = 1'b1;
                        cp_next   = full_cp[20:0];
                        seen_next = 1'b1;
                    end else begin
                        phase_next = PH_TEXT;
                        drain_next = 1'b1;
                    end
                end
                PH_TEXT: begin
                    if (s_in_byte == CH_BACKSLASH) begin
                        phase_next = PH_ESC;
                    end else begin
                        q_cmd.kind = KIND_BYTE;
                        q_cmd.cp   = {13'd0, s_in_byte};
                    end
                end
            endcase
        end

        if (s_last) begin
            if (phase_next == PH_UESC || phase_next == PH_HEX) drain_next = 1'b1;
            q_cmd.term     = 1'b1;
            q_cmd.term_err = drain_next;
            if (drain_next) q_cmd.kind = KIND_NONE;
            phase_next = PH_TEXT;
            cp_next    = 21'd0;
            ovf_next   = 1'b0;
            seen_next  = 1'b0;
            drain_next = 1'b0;
        end
    end

    assign q_push = accept && (q_cmd.kind != KIND_NONE || q_cmd.term);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TEXT;
            cp_reg    <= 21'd0;
            ovf_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            drain_reg <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cp_reg    <= cp_next;
            ovf_reg   <= ovf_next;
            seen_reg  <= seen_next;
            drain_reg <= drain_next;
        end
    end

`ifndef SYNTHESIS
    a_drain_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> phase_reg == PH_TEXT)
        else $error("drain outside text phase");
`endif

endmodule

`default_nettype wire

[sv/se2u_queue.sv]
// small command queue between scanner and byte emitter
`default_nettype none

module se2u_queue import se2u_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_data,
    output logic      empty
);

    cmd_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;

    assign full     = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

[sv/se2u_back.sv]
// back end: expands commands into output beats with utf8 encoding
`default_nettype none

module se2u_back import se2u_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_empty,
    input  wire cmd_t  q_data,
    output logic       q_pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_status,
    output logic       m_end_of_string
);

    cmd_t       cur_reg;
    logic       cur_valid_reg;
    logic [2:0] idx_reg;

    logic [2:0] len;
    logic [2:0] beats;
    logic       last_beat;
    logic       done;
    logic [20:0] cp;

    assign cp = cur_reg.cp;

    always_comb begin
        unique case (cur_reg.kind)
            KIND_BYTE: len = 3'd1;
            KIND_UTF8: begin
                if (cp >= 21'h010000)      len = 3'd4;
                else if (cp >= 21'h000800) len = 3'd3;
                else if (cp >= 21'h000080) len = 3'd2;
                else if (cp == 21'd0)      len = 3'd2;
                else                       len = 3'd1;
            end
            default: len = 3'd0;
        endcase
    end

    assign beats     = len + {2'd0, cur_reg.term};
    assign last_beat = idx_reg == beats - 3'd1;
    assign done      = m_valid && m_ready && last_beat;
    assign q_pop     = (!cur_valid_reg || done) && !q_empty;
    assign m_valid   = cur_valid_reg;

    always_comb begin
        m_out_byte      = 8'h00;
        m_status        = cur_reg.status;
        m_end_of_string = 1'b0;
        if (idx_reg >= len) begin
            m_status        = cur_reg.term_err ? ST_ERROR : ST_OK;
            m_end_of_string = 1'b1;
        end else if (cur_reg.kind == KIND_BYTE || len == 3'd1) begin
            m_out_byte = cp[7:0];
        end else if (idx_reg == len - 3'd1) begin
            m_out_byte = {2'b10, cp[5:0]};
        end else if (idx_reg != 3'd0) begin
            m_out_byte = (idx_reg == len - 3'd2) ? {2'b10, cp[11:6]} : {2'b10, cp[17:12]};
        end else begin
            unique case (len)
                3'd2:    m_out_byte = {3'b110, cp[10:6]};
                3'd3:    m_out_byte = {4'b1110, cp[15:12]};
                default: m_out_byte = {5'b11110, cp[20:18]};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) cur_reg <= q_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end else if (q_pop) begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 3'd0;
        end else if (done) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end else if (m_valid && m_ready) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> idx_reg < beats)
        else $error("beat index past command length");
    a_eos_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_string) |-> m_out_byte == 8'h00)
        else $error("end of string beat with nonzero byte");
`endif

endmodule

`default_nettype wire

[sv/string_escape_to_utf8.sv]
// top level of the backslash escape decoder with modified utf8 output
//
// input channel s_*: one string body byte per beat (s_in_byte), s_has_byte
// low for a beat that only closes an empty string, s_last on the final beat.
// output channel m_*: one decoded byte per beat with m_status (ok, empty
// unicode escape, code point too big, error) and m_end_of_string on the
// terminator or error beat that closes each string.
// the scanner takes one input beat per cycle while s_ready is high; each
// input beat gives 0 to 5 output beats, one per cycle while m_ready is
// high, with the utf8 expansion done by the emitter. a four entry command
// queue decouples the two, so s_ready drops only when the queue is full.
// an input beat's output is offered only after its queue write and pop.
// sustained rate: one input beat per cycle as long as the output side takes
// one beat per cycle and escapes do not expand beyond that on average; the
// output side is bound to one beat per cycle by the emitter.
// when m_ready is low the current beat holds and the queue fills, then
// s_ready falls. aresetn clears the scanner state, the queue and the
// emitter; no beats are held across reset.
`default_nettype none

module string_escape_to_utf8 import se2u_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_has_byte,
    input  wire logic       s_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_status,
    output logic            m_end_of_string
);

    logic q_full, q_empty, q_push, q_pop;
    cmd_t push_cmd, pop_cmd;

    se2u_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_has_byte (s_has_byte),
        .s_last     (s_last),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    se2u_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_cmd),
        .empty     (q_empty)
    );

    se2u_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_data          (pop_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_status        (m_status),
        .m_end_of_string (m_end_of_string)
    );

endmodule

`default_nettype wire
